FILE: rtl/slcg_pkg.sv
`timescale 1ns / 1ps

package slcg_pkg;

   localparam int MaxLevel = 6;
   localparam int LevelWidth = 3;
   localparam int RowWidth = $clog2((1 << MaxLevel) + 2);
   localparam int SumWidth = RowWidth + 2;
   localparam int IndexWidth = 16;
   localparam int CountWidth = 3;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = LevelWidth;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 4 * IndexWidth;

   localparam logic [CsrIndexWidth-1:0] CsrSubdivisionLevel = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrDimensionMode = 1'b1;

   typedef struct packed {
      logic [RowWidth-1:0]   row_i;
      logic [RowWidth-1:0]   row_j;
      logic [RowWidth-1:0]   row_k;
      logic [IndexWidth-1:0] point_index;
      logic [RowWidth-1:0]   steps;
      logic                  dim3;
      logic [CountWidth-1:0] count;
      logic                  mesh_end;
   } job_type;

endpackage

FILE: rtl/simplex_lattice_connectivity_generator.sv
`timescale 1ns / 1ps

// Connectivity generator for a triangle or tetrahedron subdivided into 2^level steps per edge.
// The req channel carries one transaction per lattice step: restart in bit 0 of req_tdata moves
// to the origin, otherwise the walk advances one lattice point (i-major, then j, then k).
// Each point yields zero to six simplices on the rsp channel, one transaction per simplex,
// with tlast on the final simplex of the point and tuser on the final simplex of the mesh.
// The csr port writes subdivision_level (index 0) and dimension_mode (index 1); the user must
// write them only while idle, which the block does not enforce. An accepted point is written
// to the job queue, then popped into the sequencer's registers once the sequencer is free.
// The output register then takes one simplex per cycle while rsp is not stalled; a point has
// one, two, five or six simplices, interior 3D points six. A two-entry job queue lets req accept
// a new point while the previous one is still draining; req_tready drops only when it is full.
// When rsp_tready is low the output register holds, the sequencer waits, and the queue fills.
// Reset clears the walk, empties the queue and output, sets level 0 and 3D mode; the walk
// stays idle until a restart arrives.

module simplex_lattice_connectivity_generator import slcg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,   // restart, zero fill
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // vertex_a, vertex_b, vertex_c, vertex_d
   output logic                     rsp_tlast,
   output logic                     rsp_tuser,   // last_of_mesh
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   slcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   slcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   slcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/slcg_front.sv
`timescale 1ns / 1ps

module slcg_front import slcg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     restart,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     queue_full,
   output logic                     push_valid,
   output job_type                  push_job
);

   logic [LevelWidth-1:0] level_ff;
   logic                  dim3_ff;
   logic [RowWidth-1:0]   row_i_ff, row_i_in;
   logic [RowWidth-1:0]   row_j_ff, row_j_in;
   logic [RowWidth-1:0]   row_k_ff, row_k_in;
   logic [IndexWidth-1:0] point_index_ff, point_index_in;
   logic                  running_ff, running_in;

   logic [LevelWidth-1:0] level_clamped;
   logic [RowWidth-1:0]   steps;
   logic [SumWidth-1:0]   steps_ext;
   logic [SumWidth-1:0]   sum_ij_inc;
   logic [SumWidth-1:0]   sum_ijk_inc;
   logic [SumWidth-1:0]   emit_sum;
   logic                  emit;
   logic                  accept;
   logic [CountWidth-1:0] count;

   assign level_clamped = (level_ff > LevelWidth'(MaxLevel)) ? LevelWidth'(MaxLevel) : level_ff;
   assign steps = RowWidth'(1) << level_clamped;
   assign steps_ext = SumWidth'(steps);
   assign sum_ij_inc = SumWidth'(row_i_ff) + SumWidth'(row_j_ff) + SumWidth'(1);
   assign sum_ijk_inc = sum_ij_inc + SumWidth'(row_k_ff);

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      row_i_in = row_i_ff;
      row_j_in = row_j_ff;
      row_k_in = row_k_ff;
      point_index_in = point_index_ff;
      running_in = running_ff;
      if (restart) begin
         row_i_in = '0;
         row_j_in = '0;
         row_k_in = '0;
         point_index_in = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         point_index_in = point_index_ff + IndexWidth'(1);
         if (dim3_ff && (sum_ijk_inc <= steps_ext)) begin
            row_k_in = row_k_ff + RowWidth'(1);
         end else begin
            row_k_in = '0;
            row_j_in = row_j_ff + RowWidth'(1);
            if (sum_ij_inc > steps_ext) begin
               row_j_in = '0;
               row_i_in = row_i_ff + RowWidth'(1);
               if (SumWidth'(row_i_ff) + SumWidth'(1) > steps_ext) begin
                  running_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      emit_sum = SumWidth'(row_i_in) + SumWidth'(row_j_in) + SumWidth'(row_k_in);
      emit = running_in && (emit_sum < steps_ext);
      if (emit_sum + SumWidth'(1) >= steps_ext) begin
         count = CountWidth'(1);
      end else if (!dim3_ff) begin
         count = CountWidth'(2);
      end else if (emit_sum + SumWidth'(2) >= steps_ext) begin
         count = CountWidth'(5);
      end else begin
         count = CountWidth'(6);
      end
   end

   assign push_valid = accept && emit;
   assign push_job.row_i = row_i_in;
   assign push_job.row_j = row_j_in;
   assign push_job.row_k = row_k_in;
   assign push_job.point_index = point_index_in;
   assign push_job.steps = steps;
   assign push_job.dim3 = dim3_ff;
   assign push_job.count = count;
   assign push_job.mesh_end = (SumWidth'(row_i_in) + SumWidth'(1) == steps_ext)
                              && (row_j_in == '0) && (row_k_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         dim3_ff <= 1'b1;
         row_i_ff <= '0;
         row_j_ff <= '0;
         row_k_ff <= '0;
         point_index_ff <= '0;
         running_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CsrSubdivisionLevel: level_ff <= csr_wdata;
               CsrDimensionMode:    dim3_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            row_i_ff <= row_i_in;
            row_j_ff <= row_j_in;
            row_k_ff <= row_k_in;
            point_index_ff <= point_index_in;
            running_ff <= running_in;
         end
      end
   end

endmodule

FILE: rtl/slcg_queue.sv
`timescale 1ns / 1ps

module slcg_queue import slcg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type                    entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0]     fill_ff;

   assign full = (fill_ff == (QueuePtrWidth + 1)'(QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QueuePtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrWidth'(1);
         end
         if (push_valid && !pop) begin
            fill_ff <= fill_ff + (QueuePtrWidth + 1)'(1);
         end else if (pop && !push_valid) begin
            fill_ff <= fill_ff - (QueuePtrWidth + 1)'(1);
         end
      end
   end

endmodule

FILE: rtl/slcg_back.sv
`timescale 1ns / 1ps

module slcg_back import slcg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  job_type                 head_job,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tuser
);

   logic                  busy_ff, busy_in;
   logic [CountWidth-1:0] seq_ff, seq_in;
   logic [CountWidth-1:0] count_ff;
   logic                  dim3_ff;
   logic                  mesh_ff;
   logic [IndexWidth-1:0] vp_ff, vpk_ff, vpj_ff, vpi_ff, vpkj_ff, vpij_ff, vpki_ff, vpkij_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0]   out_a_ff, out_b_ff, out_c_ff, out_d_ff;
   logic                    out_lop_ff, out_lom_ff;

   logic [RowWidth-1:0]     side;
   logic [RowWidth-1:0]     diff;
   logic [RowWidth-1:0]     diff_inc;
   logic [2*RowWidth-1:0]   tri_prod;
   logic [IndexWidth-1:0]   j_sub;
   logic [IndexWidth-1:0]   new_pj, new_pi, new_pij;

   logic                    adv;
   logic                    last;
   logic [IndexWidth-1:0]   sel_a, sel_b, sel_c, sel_d;

   assign side = head_job.steps + RowWidth'(1);
   assign diff = side - head_job.row_i;
   assign diff_inc = diff + RowWidth'(1);
   assign tri_prod = (2*RowWidth)'(diff) * (2*RowWidth)'(diff_inc);
   assign j_sub = IndexWidth'(head_job.row_j);
   assign new_pj = head_job.point_index + IndexWidth'(diff)
                   - (head_job.dim3 ? j_sub : IndexWidth'(0));
   assign new_pi = head_job.point_index + IndexWidth'(tri_prod >> 1) - j_sub;
   assign new_pij = new_pi + IndexWidth'(diff) - IndexWidth'(1) - j_sub;

   assign adv = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign last = (seq_ff == count_ff - CountWidth'(1));
   assign pop = head_valid && (!busy_ff || (adv && last));

   always_comb begin
      sel_a = vp_ff;
      sel_b = vpk_ff;
      sel_c = vpj_ff;
      sel_d = dim3_ff ? vpi_ff : '0;
      case (seq_ff)
         CountWidth'(1): begin
            sel_a = vpk_ff;
            sel_b = vpkj_ff;
            sel_c = vpj_ff;
         end
         CountWidth'(2): begin
            sel_a = vpk_ff;
            sel_b = vpkj_ff;
            sel_c = vpki_ff;
         end
         CountWidth'(3): begin
            sel_a = vpj_ff;
            sel_b = vpi_ff;
            sel_c = vpkj_ff;
            sel_d = vpij_ff;
         end
         CountWidth'(4): begin
            sel_a = vpi_ff;
            sel_b = vpkj_ff;
            sel_c = vpij_ff;
            sel_d = vpki_ff;
         end
         CountWidth'(5): begin
            sel_a = vpkj_ff;
            sel_b = vpij_ff;
            sel_c = vpki_ff;
            sel_d = vpkij_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      seq_in = seq_ff;
      if (pop) begin
         busy_in = 1'b1;
         seq_in = '0;
      end else if (adv) begin
         seq_in = seq_ff + CountWidth'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         count_ff <= head_job.count;
         dim3_ff <= head_job.dim3;
         mesh_ff <= head_job.mesh_end;
         vp_ff <= head_job.point_index;
         vpk_ff <= head_job.point_index + IndexWidth'(1);
         vpj_ff <= new_pj;
         vpkj_ff <= new_pj + IndexWidth'(1);
         vpi_ff <= new_pi;
         vpki_ff <= new_pi + IndexWidth'(1);
         vpij_ff <= new_pij;
         vpkij_ff <= new_pij + IndexWidth'(1);
      end
      if (adv) begin
         out_a_ff <= sel_a;
         out_b_ff <= sel_b;
         out_c_ff <= sel_c;
         out_d_ff <= sel_d;
         out_lop_ff <= last;
         out_lom_ff <= last && mesh_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {out_d_ff, out_c_ff, out_b_ff, out_a_ff};
   assign rsp_tlast = out_lop_ff;
   assign rsp_tuser = out_lom_ff;

endmodule

FILE: rtl/slcg_checker.sv
`timescale 1ns / 1ps

module slcg_checker import slcg_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tlast,
   input logic                    rsp_tuser
);

   // A stalled transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // Reset empties the output stage.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // The final simplex of the mesh is always the final simplex of its point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("last_of_mesh without last_of_point");

endmodule

bind simplex_lattice_connectivity_generator slcg_checker u_slcg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import slcg_pkg::*;

   localparam bit Mode2d = 1'b0;
   localparam bit Mode3d = 1'b1;
   localparam int RandomSteps = 440;
   localparam int SettleCycles = 16;

   typedef enum logic {ROW_STEP, ROW_CONFIG} row_kind_type;

   typedef struct {
      logic [IndexWidth-1:0] vertex_a;
      logic [IndexWidth-1:0] vertex_b;
      logic [IndexWidth-1:0] vertex_c;
      logic [IndexWidth-1:0] vertex_d;
      logic                  last_of_point;
      logic                  last_of_mesh;
   } simplex_type;

   typedef struct {
      row_kind_type          kind;
      bit                    restart;
      bit [LevelWidth-1:0]   level;
      bit                    dim;
      bit                    typed;
      int                    typed_count;
      simplex_type           typed_simplex;
   } stimulus_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   simplex_lattice_connectivity_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Model state of the lattice walk and its registers.
   bit [LevelWidth-1:0] cfg_level;
   bit                  cfg_dim;
   int unsigned         walk_i;
   int unsigned         walk_j;
   int unsigned         walk_k;
   int unsigned         walk_index;
   bit                  walk_active;

   simplex_type         point_simplices[6];
   int                  point_count;
   simplex_type         pending_simplices[$];
   stimulus_row_type    plan[$];
   int                  mismatches = 0;
   int                  sent_steps = 0;
   bit                  no_gaps = 1'b0;
   int unsigned         rsp_pause = 0;

   task automatic put_simplex(input int unsigned a, input int unsigned b,
                              input int unsigned c, input int unsigned d);
      point_simplices[point_count].vertex_a = a[15:0];
      point_simplices[point_count].vertex_b = b[15:0];
      point_simplices[point_count].vertex_c = c[15:0];
      point_simplices[point_count].vertex_d = d[15:0];
      point_simplices[point_count].last_of_point = 1'b0;
      point_simplices[point_count].last_of_mesh = 1'b0;
      point_count++;
   endtask

   task automatic walk_lattice_point(input bit restart);
      int unsigned r, s, sum, p, pk, pj, pi, pkj, pij, pki, pkij, pu;
      bit moved;
      point_count = 0;
      r = 1 << ((cfg_level > MaxLevel) ? MaxLevel : cfg_level);
      if (restart) begin
         walk_i = 0;
         walk_j = 0;
         walk_k = 0;
         walk_index = 0;
         walk_active = 1'b1;
      end else begin
         if (!walk_active) return;
         moved = 1'b0;
         if (cfg_dim == Mode3d) begin
            walk_k++;
            if (walk_i + walk_j + walk_k <= r) moved = 1'b1;
            else walk_k = 0;
         end else begin
            walk_k = 0;
         end
         if (!moved) begin
            walk_j++;
            if (walk_i + walk_j > r) begin
               walk_j = 0;
               walk_i++;
               if (walk_i > r) walk_active = 1'b0;
            end
         end
         walk_index = (walk_index + 1) & 32'hFFFF;
         if (!walk_active) return;
      end
      if (cfg_dim == Mode2d) walk_k = 0;
      s = r + 1;
      p = walk_index;
      if (cfg_dim == Mode3d) begin
         sum = walk_i + walk_j + walk_k;
         if (sum >= r) return;
         pk = p + 1;
         pj = p + s - walk_i - walk_j;
         pi = p + (s - walk_i) * (s + 1 - walk_i) / 2 - walk_j;
         pkj = pj + 1;
         pij = pi + s - (walk_i + 1) - walk_j;
         pki = pi + 1;
         pkij = pij + 1;
         put_simplex(p, pk, pj, pi);
         if (sum + 1 < r) begin
            put_simplex(pk, pkj, pj, pi);
            put_simplex(pk, pkj, pki, pi);
            put_simplex(pj, pi, pkj, pij);
            put_simplex(pi, pkj, pij, pki);
            if (sum + 2 < r) put_simplex(pkj, pij, pki, pkij);
         end
      end else begin
         sum = walk_i + walk_j;
         if (sum >= r) return;
         pu = p + s - walk_i;
         put_simplex(p, p + 1, pu, 0);
         if (sum + 1 < r) put_simplex(p + 1, pu + 1, pu, 0);
      end
      point_simplices[point_count-1].last_of_point = 1'b1;
      if (walk_i + 1 == r && walk_j == 0 && walk_k == 0)
         point_simplices[point_count-1].last_of_mesh = 1'b1;
   endtask

   task automatic send_step(input stimulus_row_type row);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(ReqDataWidth-1){1'b0}}, row.restart};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sent_steps++;
      walk_lattice_point(row.restart);
      if (row.typed) begin
         if (row.typed_count != 0) pending_simplices.push_back(row.typed_simplex);
      end else begin
         for (int n = 0; n < point_count; n++) pending_simplices.push_back(point_simplices[n]);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_simplices.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic program_walk(input bit [LevelWidth-1:0] level, input bit dim);
      csr_wr_en <= 1'b1;
      csr_index <= CsrSubdivisionLevel;
      csr_wdata <= level;
      @(posedge clock);
      csr_index <= CsrDimensionMode;
      csr_wdata <= {{(CsrDataWidth-1){1'b0}}, dim};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_level = level;
      cfg_dim = dim;
   endtask

   task automatic add_step(input bit restart);
      stimulus_row_type row;
      row = '{kind: ROW_STEP, restart: restart, level: '0, dim: 1'b0, typed: 1'b0,
              typed_count: 0, typed_simplex: '{default: '0}};
      plan.push_back(row);
   endtask

   task automatic add_typed(input bit restart, input int count, input int a, input int b,
                            input int c, input int d);
      stimulus_row_type row;
      row = '{kind: ROW_STEP, restart: restart, level: '0, dim: 1'b0, typed: 1'b1,
              typed_count: count, typed_simplex: '{default: '0}};
      row.typed_simplex.vertex_a = IndexWidth'(a);
      row.typed_simplex.vertex_b = IndexWidth'(b);
      row.typed_simplex.vertex_c = IndexWidth'(c);
      row.typed_simplex.vertex_d = IndexWidth'(d);
      row.typed_simplex.last_of_point = 1'b1;
      row.typed_simplex.last_of_mesh = 1'b1;
      plan.push_back(row);
   endtask

   task automatic add_config(input bit [LevelWidth-1:0] level, input bit dim);
      stimulus_row_type row;
      row = '{kind: ROW_CONFIG, restart: 1'b0, level: level, dim: dim, typed: 1'b0,
              typed_count: 0, typed_simplex: '{default: '0}};
      plan.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_pacer
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_pause <= 0;
      end else if (rsp_pause != 0) begin
         rsp_pause <= rsp_pause - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = no_gaps ? 0 : $urandom_range(0, 3);
         rsp_pause <= (pause == 0) ? 0 : pause - 1;
         rsp_tready <= (pause == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_checker
      simplex_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_simplices.size() == 0) begin
            $error("unexpected rsp transaction %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_simplices.pop_front();
            if (rsp_tdata[15:0] !== want.vertex_a) begin
               $error("vertex_a expected %0d got %0d", want.vertex_a, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.vertex_b) begin
               $error("vertex_b expected %0d got %0d", want.vertex_b, rsp_tdata[31:16]);
               mismatches++;
            end
            if (rsp_tdata[47:32] !== want.vertex_c) begin
               $error("vertex_c expected %0d got %0d", want.vertex_c, rsp_tdata[47:32]);
               mismatches++;
            end
            if (rsp_tdata[63:48] !== want.vertex_d) begin
               $error("vertex_d expected %0d got %0d", want.vertex_d, rsp_tdata[63:48]);
               mismatches++;
            end
            if (rsp_tlast !== want.last_of_point) begin
               $error("last_of_point expected %0d got %0d", want.last_of_point, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.last_of_mesh) begin
               $error("last_of_mesh expected %0d got %0d", want.last_of_mesh, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simplex_lattice_connectivity_generator: mismatch");
      $finish;
   end

   initial begin
      stimulus_row_type row;
      int unsigned pick;
      int unsigned span;
      bit [LevelWidth-1:0] level;

      cfg_level = 0;
      cfg_dim = Mode3d;
      walk_i = 0;
      walk_j = 0;
      walk_k = 0;
      walk_index = 0;
      walk_active = 1'b0;

      // Idle before restart, the level-0 tetrahedron and triangle, and their empty points.
      add_typed(1'b0, 0, 0, 0, 0, 0);
      add_typed(1'b1, 1, 0, 1, 2, 3);
      repeat (4) add_typed(1'b0, 0, 0, 0, 0, 0);
      add_typed(1'b0, 0, 0, 0, 0, 0);
      add_config(3'd0, Mode2d);
      add_typed(1'b1, 1, 0, 1, 2, 0);
      repeat (3) add_typed(1'b0, 0, 0, 0, 0, 0);
      add_config(3'd7, Mode3d);
      add_step(1'b1);
      add_step(1'b0);
      add_config(3'd1, Mode3d);
      add_step(1'b1);
      repeat (3) add_step(1'b0);
      add_config(3'd2, Mode2d);
      add_step(1'b1);
      repeat (2) add_step(1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[n]) begin
         if (plan[n].kind == ROW_CONFIG) begin
            settle();
            program_walk(plan[n].level, plan[n].dim);
         end else begin
            send_step(plan[n]);
         end
      end

      sent_steps = 0;
      row = '{kind: ROW_STEP, restart: 1'b0, level: '0, dim: 1'b0, typed: 1'b0,
              typed_count: 0, typed_simplex: '{default: '0}};
      while (sent_steps < RandomSteps) begin
         settle();
         no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) level = LevelWidth'($urandom_range(0, 3));
         else level = LevelWidth'(pick - 2);
         program_walk(level, 1'($urandom_range(0, 1)));
         span = (level > 3) ? $urandom_range(3, 12) : $urandom_range(5, 40);
         for (int n = 0; n < span; n++) begin
            if (n == 0) row.restart = ($urandom_range(0, 4) != 0);
            else row.restart = ($urandom_range(0, 29) == 0);
            send_step(row);
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("simplex_lattice_connectivity_generator: match");
      end else begin
         $display("simplex_lattice_connectivity_generator: mismatch");
      end
      $finish;
   end

endmodule
